// ===== hw/rtl/emb_pkg.sv =====
// shared types and constants for the emulated memory bus decoder
// no dependencies; imported by the interfaces, the decoder and the top level
`default_nettype none

package emb_pkg;

    localparam int ADDR_W        = 24;
    localparam int DATA_W        = 32;
    localparam int WIDTH_W       = 3;
    localparam int ROMLEN_W      = 23;
    localparam int CFG_IDX_W     = 2;
    localparam int RAM_AW        = 16;
    localparam int RAM_BYTES     = 65536;
    localparam int ROM_BYTES_DEF = 4194304;

    localparam logic [ADDR_W-1:0] RAM_BASE  = 24'hff0000;
    localparam logic [ADDR_W-1:0] ROM_LIMIT = 24'h400000;

    localparam logic [CFG_IDX_W-1:0] CFG_ROM_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_READ   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_WRITE  = 2'd2;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_LOAD  = 2'd2,
        OP_BAD   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_RAM   = 3'd0,
        ST_ROM   = 3'd1,
        ST_DEV   = 3'd2,
        ST_FAULT = 3'd3,
        ST_ROMWR = 3'd4,
        ST_LOAD  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_RAM_RD = 3'd1,
        ACT_RAM_WR = 3'd2,
        ACT_ROM_RD = 3'd3,
        ACT_ROM_LD = 3'd4
    } t_act;

    typedef struct packed {
        t_status status;
        t_act    act;
    } t_dec;

endpackage

`default_nettype wire

// ===== hw/rtl/emb_if.sv =====
// valid/ready channel interfaces: access items in, results out, config writes
// depends on emb_pkg for field widths
`default_nettype none

interface emb_in_if
    import emb_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [1:0]           operation;
    logic [ADDR_W-1:0]    bus_address;
    logic [WIDTH_W-1:0]   width_bytes;
    logic [DATA_W-1:0]    write_value;

    modport source (output valid, operation, bus_address, width_bytes, write_value,
                    input ready);
    modport sink   (input valid, operation, bus_address, width_bytes, write_value,
                    output ready);
endinterface

interface emb_out_if
    import emb_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [DATA_W-1:0]    read_data;
    logic [2:0]           status;
    logic [DATA_W-1:0]    fault_total;
    logic [ADDR_W-1:0]    last_fault_addr;
    logic [ADDR_W-1:0]    dev_address;
    logic [WIDTH_W-1:0]   dev_width;
    logic [DATA_W-1:0]    dev_value;

    modport source (output valid, read_data, status, fault_total, last_fault_addr,
                    dev_address, dev_width, dev_value, input ready);
    modport sink   (input valid, read_data, status, fault_total, last_fault_addr,
                    dev_address, dev_width, dev_value, output ready);
endinterface

interface emb_cfg_if
    import emb_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [ROMLEN_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/emb_ram.sv =====
// generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module emb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/emb_decode.sv =====
// address and operation decode: picks result status and memory action
// depends on emb_pkg
`default_nettype none

module emb_decode
    import emb_pkg::*;
#(
    parameter int ROM_BYTES = ROM_BYTES_DEF
) (
    input  wire t_op                  i_op,
    input  wire logic [ADDR_W-1:0]    i_addr,
    input  wire logic [WIDTH_W-1:0]   i_width,
    input  wire logic [ROMLEN_W-1:0]  i_rom_length,
    input  wire logic                 i_dev_rd,
    input  wire logic                 i_dev_wr,
    output t_dec                      o_dec
);

    localparam logic [ADDR_W-1:0] ROM_END = ADDR_W'(ROM_BYTES);

    logic              width_ok;
    logic [ADDR_W-1:0] rom_len;
    logic [ADDR_W-1:0] end_addr;
    logic              present;

    always_comb begin
        width_ok = (i_width == 3'd1) || (i_width == 3'd2) || (i_width == 3'd4);
        rom_len  = ({1'b0, i_rom_length} > ROM_END) ? ROM_END : {1'b0, i_rom_length};
        end_addr = i_addr + ADDR_W'(i_width);
        present  = (i_op == OP_READ) ? i_dev_rd : i_dev_wr;

        o_dec.status = ST_FAULT;
        o_dec.act    = ACT_NONE;
        if (i_op == OP_LOAD) begin
            if (i_addr < ROM_END) begin
                o_dec.status = ST_LOAD;
                o_dec.act    = ACT_ROM_LD;
            end
        end else if (i_op == OP_BAD || !width_ok) begin
            o_dec.status = ST_FAULT;
        end else if (i_addr >= RAM_BASE) begin
            o_dec.status = ST_RAM;
            o_dec.act    = (i_op == OP_READ) ? ACT_RAM_RD : ACT_RAM_WR;
        end else if (i_addr < ROM_LIMIT) begin
            if (i_op == OP_READ) begin
                if (end_addr <= rom_len) begin
                    o_dec.status = ST_ROM;
                    o_dec.act    = ACT_ROM_RD;
                end
            end else begin
                o_dec.status = ST_ROMWR;
            end
        end else if (present) begin
            o_dec.status = ST_DEV;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/emulated_memory_bus_decoder_core.sv =====
// top level of the emulated memory bus decoder: byte sequencer over work RAM and ROM
// depends on emb_pkg, emb_if, emb_ram and emb_decode
//
// usage
//   i_in takes one access item (read, write or ROM byte load) while ready is high;
//   ready is high only while the block is idle, so items are handled one at a time.
//   o_out returns exactly one result item per access from an output register.
//   i_cfg writes rom_length (0), device_read_present (1), device_write_present (2);
//   it is always ready and is meant to be written while no access is in flight.
// sequence
//   an accepted item is decoded in S_DEC, then S_XFER moves one byte of RAM or ROM
//   per cycle through a single memory port; a read takes its last byte in S_TAIL,
//   and S_FIN loads o_out. faults, device accesses and ignored ROM writes skip S_XFER;
//   a new item is taken only after S_FIN loads the result and the block is idle.
// reset
//   a clearing pass writes zero to all 65536 work RAM bytes, one per cycle;
//   i_in stays not ready until the pass ends. ROM contents are not cleared.
// stall
//   a result waiting on o_out does not block the next access; the block finishes
//   that access and holds it until the output register is free.
`default_nettype none

module emulated_memory_bus_decoder_core
    import emb_pkg::*;
#(
    parameter int ROM_BYTES = ROM_BYTES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    emb_in_if.sink     i_in,
    emb_out_if.source  o_out,
    emb_cfg_if.sink    i_cfg
);

    localparam int ROM_AW = (ROM_BYTES > 1) ? $clog2(ROM_BYTES) : 1;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_DEC   = 6'b000100,
        S_XFER  = 6'b001000,
        S_TAIL  = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic [RAM_AW-1:0]    r_clr, n_clr;
    logic                 r_out_valid, n_out_valid;
    logic [DATA_W-1:0]    r_fault_cnt, n_fault_cnt;
    logic [ADDR_W-1:0]    r_fault_addr, n_fault_addr;
    logic [ROMLEN_W-1:0]  r_rom_length, n_rom_length;
    logic                 r_dev_rd, n_dev_rd;
    logic                 r_dev_wr, n_dev_wr;

    t_op                  r_op, n_op;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic [WIDTH_W-1:0]   r_width, n_width;
    logic [DATA_W-1:0]    r_val, n_val;
    logic [DATA_W-1:0]    r_wval, n_wval;
    t_dec                 r_dec, n_dec;
    logic [WIDTH_W-1:0]   r_idx, n_idx;
    logic                 r_pend, n_pend;
    logic [DATA_W-1:0]    r_rd, n_rd;

    logic [DATA_W-1:0]    r_o_rd, n_o_rd;
    t_status              r_o_status, n_o_status;
    logic [DATA_W-1:0]    r_o_fcnt, n_o_fcnt;
    logic [ADDR_W-1:0]    r_o_faddr, n_o_faddr;
    logic [ADDR_W-1:0]    r_o_daddr, n_o_daddr;
    logic [WIDTH_W-1:0]   r_o_dwidth, n_o_dwidth;
    logic [DATA_W-1:0]    r_o_dval, n_o_dval;

    t_dec                 dec;
    logic [ADDR_W-1:0]    byte_addr;
    logic                 is_last;
    logic [7:0]           rd_byte;
    logic                 out_load;
    logic                 in_acc;
    logic                 cfg_acc;

    logic                 ram_we;
    logic [RAM_AW-1:0]    ram_waddr;
    logic [7:0]           ram_wdata;
    logic [RAM_AW-1:0]    ram_raddr;
    logic [7:0]           ram_rdata;
    logic                 rom_we;
    logic [ROM_AW-1:0]    rom_waddr;
    logic [7:0]           rom_wdata;
    logic [ROM_AW-1:0]    rom_raddr;
    logic [7:0]           rom_rdata;

    emb_decode #(
        .ROM_BYTES(ROM_BYTES)
    ) u_decode (
        .i_op        (r_op),
        .i_addr      (r_addr),
        .i_width     (r_width),
        .i_rom_length(r_rom_length),
        .i_dev_rd    (r_dev_rd),
        .i_dev_wr    (r_dev_wr),
        .o_dec       (dec)
    );

    emb_ram #(
        .WIDTH(8),
        .DEPTH(RAM_BYTES)
    ) u_work_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    emb_ram #(
        .WIDTH(8),
        .DEPTH(ROM_BYTES)
    ) u_rom (
        .i_clk  (i_clk),
        .i_we   (rom_we),
        .i_waddr(rom_waddr),
        .i_wdata(rom_wdata),
        .i_raddr(rom_raddr),
        .o_rdata(rom_rdata)
    );

    assign in_acc    = i_in.valid && i_in.ready;
    assign cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign byte_addr = r_addr + ADDR_W'(r_idx);
    assign is_last   = (r_idx == (r_width - WIDTH_W'(1)));
    assign rd_byte   = (r_dec.act == ACT_ROM_RD) ? rom_rdata : ram_rdata;

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_fault_cnt  = r_fault_cnt;
        n_fault_addr = r_fault_addr;
        n_rom_length = r_rom_length;
        n_dev_rd     = r_dev_rd;
        n_dev_wr     = r_dev_wr;
        n_op         = r_op;
        n_addr       = r_addr;
        n_width      = r_width;
        n_val        = r_val;
        n_wval       = r_wval;
        n_dec        = r_dec;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_rd         = r_rd;
        n_o_rd       = r_o_rd;
        n_o_status   = r_o_status;
        n_o_fcnt     = r_o_fcnt;
        n_o_faddr    = r_o_faddr;
        n_o_daddr    = r_o_daddr;
        n_o_dwidth   = r_o_dwidth;
        n_o_dval     = r_o_dval;
        out_load     = 1'b0;

        ram_we    = 1'b0;
        ram_waddr = byte_addr[RAM_AW-1:0];
        ram_wdata = r_wval[DATA_W-1 -: 8];
        ram_raddr = byte_addr[RAM_AW-1:0];
        rom_we    = 1'b0;
        rom_waddr = r_addr[ROM_AW-1:0];
        rom_wdata = r_val[7:0];
        rom_raddr = byte_addr[ROM_AW-1:0];

        if (cfg_acc) begin
            case (i_cfg.index)
                CFG_ROM_LENGTH: n_rom_length = i_cfg.data;
                CFG_DEV_READ:   n_dev_rd     = i_cfg.data[0];
                CFG_DEV_WRITE:  n_dev_wr     = i_cfg.data[0];
                default: ;
            endcase
        end

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + RAM_AW'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_op    = t_op'(i_in.operation);
                    n_addr  = i_in.bus_address;
                    n_width = i_in.width_bytes;
                    n_val   = i_in.write_value;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_dec  = dec;
                n_idx  = '0;
                n_pend = 1'b0;
                n_rd   = '0;
                case (r_width)
                    3'd1:    n_wval = r_val << 24;
                    3'd2:    n_wval = r_val << 16;
                    default: n_wval = r_val;
                endcase
                n_state = (dec.act == ACT_NONE) ? S_FIN : S_XFER;
            end
            S_XFER: begin
                case (r_dec.act)
                    ACT_RAM_RD, ACT_ROM_RD: begin
                        n_pend = 1'b1;
                        n_idx  = r_idx + WIDTH_W'(1);
                        if (r_pend) begin
                            n_rd = {r_rd[DATA_W-9:0], rd_byte};
                        end
                        if (is_last) begin
                            n_state = S_TAIL;
                        end
                    end
                    ACT_RAM_WR: begin
                        ram_we = 1'b1;
                        n_wval = r_wval << 8;
                        n_idx  = r_idx + WIDTH_W'(1);
                        if (is_last) begin
                            n_state = S_FIN;
                        end
                    end
                    ACT_ROM_LD: begin
                        rom_we  = 1'b1;
                        n_state = S_FIN;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_TAIL: begin
                n_rd    = {r_rd[DATA_W-9:0], rd_byte};
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    if (r_dec.status == ST_FAULT) begin
                        n_fault_cnt  = r_fault_cnt + DATA_W'(1);
                        n_fault_addr = r_addr;
                    end
                    n_o_rd     = r_rd;
                    n_o_status = r_dec.status;
                    n_o_fcnt   = n_fault_cnt;
                    n_o_faddr  = n_fault_addr;
                    if (r_dec.status == ST_DEV) begin
                        n_o_daddr  = r_addr;
                        n_o_dwidth = r_width;
                        n_o_dval   = (r_op == OP_WRITE) ? r_val : '0;
                    end else begin
                        n_o_daddr  = '0;
                        n_o_dwidth = '0;
                        n_o_dval   = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
            r_fault_cnt  <= '0;
            r_fault_addr <= '0;
            r_rom_length <= '0;
            r_dev_rd     <= 1'b0;
            r_dev_wr     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_out_valid  <= n_out_valid;
            r_fault_cnt  <= n_fault_cnt;
            r_fault_addr <= n_fault_addr;
            r_rom_length <= n_rom_length;
            r_dev_rd     <= n_dev_rd;
            r_dev_wr     <= n_dev_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_addr     <= n_addr;
        r_width    <= n_width;
        r_val      <= n_val;
        r_wval     <= n_wval;
        r_dec      <= n_dec;
        r_idx      <= n_idx;
        r_pend     <= n_pend;
        r_rd       <= n_rd;
        r_o_rd     <= n_o_rd;
        r_o_status <= n_o_status;
        r_o_fcnt   <= n_o_fcnt;
        r_o_faddr  <= n_o_faddr;
        r_o_daddr  <= n_o_daddr;
        r_o_dwidth <= n_o_dwidth;
        r_o_dval   <= n_o_dval;
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign i_cfg.ready           = 1'b1;
    assign o_out.valid           = r_out_valid;
    assign o_out.read_data       = r_o_rd;
    assign o_out.status          = r_o_status;
    assign o_out.fault_total     = r_o_fcnt;
    assign o_out.last_fault_addr = r_o_faddr;
    assign o_out.dev_address     = r_o_daddr;
    assign o_out.dev_width       = r_o_dwidth;
    assign o_out.dev_value       = r_o_dval;

    a_fault_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_dec.status == ST_FAULT) |=>
            (r_fault_cnt == $past(r_fault_cnt) + DATA_W'(1)))
        else $error("fault counter did not advance on a fault result");

    a_read_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_RAM && o_out.status != ST_ROM) |->
            (o_out.read_data == '0))
        else $error("read data nonzero on a result without memory read");

    a_byte_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_XFER && r_dec.act != ACT_ROM_LD) |-> (r_idx < r_width))
        else $error("byte index ran past the access width");

endmodule

`default_nettype wire

// ===== test/tb_emulated_memory_bus_decoder_core.sv =====
`timescale 1ns / 1ps
// testbench for emulated_memory_bus_decoder_core: directed and random access items
// with a predicting scoreboard; depends on emb_pkg, the emb_*_if interfaces and the rtl

module tb_emulated_memory_bus_decoder_core;
    import emb_pkg::*;

    localparam int WATCHDOG_LIMIT = 300000;
    localparam int PHASE_ITEMS    = 310;

    typedef struct packed {
        t_op                op;
        logic [ADDR_W-1:0]  addr;
        logic [WIDTH_W-1:0] width;
        logic [DATA_W-1:0]  value;
    } bus_access_t;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic [2:0]         status;
        logic [DATA_W-1:0]  fault_total;
        logic [ADDR_W-1:0]  fault_addr;
        logic [ADDR_W-1:0]  dev_addr;
        logic [WIDTH_W-1:0] dev_width;
        logic [DATA_W-1:0]  dev_value;
    } bus_result_t;

    class bus_decode_checker;
        bit [7:0]          ram [RAM_BYTES];
        bit [7:0]          rom [int];
        bit [DATA_W-1:0]   faults;
        bit [ADDR_W-1:0]   fault_addr;
        bit [ROMLEN_W-1:0] rom_len;
        bit                dev_rd;
        bit                dev_wr;
        bus_result_t       pending_results [$];
        int                errors;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ROMLEN_W-1:0] data);
            if (idx == CFG_ROM_LENGTH) begin
                rom_len = data;
            end else if (idx == CFG_DEV_READ) begin
                dev_rd = data[0];
            end else if (idx == CFG_DEV_WRITE) begin
                dev_wr = data[0];
            end
        endfunction

        function int unsigned rom_limit();
            return (rom_len > ROM_BYTES_DEF) ? ROM_BYTES_DEF : rom_len;
        endfunction

        // an in-bounds rom read that would touch a byte never loaded
        function bit rom_gap(logic [ADDR_W-1:0] addr, logic [WIDTH_W-1:0] w);
            int unsigned len;
            len = rom_limit();
            if (addr >= len || w > len - addr) return 1'b0;
            for (int i = 0; i < w; i++) begin
                if (!rom.exists(int'(addr) + i)) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void record_fault(logic [ADDR_W-1:0] addr);
            faults     = faults + 1;
            fault_addr = addr;
        endfunction

        function void note_access(bus_access_t a);
            bus_result_t  r;
            bit           width_ok;
            int unsigned  len;
            logic [15:0]  idx;
            r        = '0;
            r.status = ST_FAULT;
            width_ok = (a.width == 1 || a.width == 2 || a.width == 4);
            if (a.op == OP_LOAD) begin
                if (a.addr < ROM_BYTES_DEF) begin
                    rom[int'(a.addr)] = a.value[7:0];
                    r.status = ST_LOAD;
                end else begin
                    record_fault(a.addr);
                end
            end else if (a.op == OP_BAD || !width_ok) begin
                record_fault(a.addr);
            end else if (a.addr >= RAM_BASE) begin
                for (int i = 0; i < a.width; i++) begin
                    idx = a.addr[15:0] + 16'(i);
                    if (a.op == OP_READ) begin
                        r.read_data = {r.read_data[23:0], ram[idx]};
                    end else begin
                        ram[idx] = 8'(a.value >> (8 * (a.width - 1 - i)));
                    end
                end
                r.status = ST_RAM;
            end else if (a.addr < ROM_LIMIT) begin
                if (a.op == OP_READ) begin
                    len = rom_limit();
                    if (a.addr >= len || a.width > len - a.addr) begin
                        record_fault(a.addr);
                    end else begin
                        for (int i = 0; i < a.width; i++) begin
                            r.read_data = {r.read_data[23:0], rom[int'(a.addr) + i]};
                        end
                        r.status = ST_ROM;
                    end
                end else begin
                    r.status = ST_ROMWR;
                end
            end else if ((a.op == OP_READ) ? dev_rd : dev_wr) begin
                r.status    = ST_DEV;
                r.dev_addr  = a.addr;
                r.dev_width = a.width;
                r.dev_value = (a.op == OP_WRITE) ? a.value : '0;
            end else begin
                record_fault(a.addr);
            end
            r.fault_total = faults;
            r.fault_addr  = fault_addr;
            pending_results.push_back(r);
        endfunction

        function void check_field(string name, logic [DATA_W-1:0] want,
                                  logic [DATA_W-1:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(bus_result_t got);
            bus_result_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, expected none, actual status %h",
                         $time, got.status);
                return;
            end
            want = pending_results.pop_front();
            check_field("read_data", want.read_data, got.read_data);
            check_field("status", DATA_W'(want.status), DATA_W'(got.status));
            check_field("fault_total", want.fault_total, got.fault_total);
            check_field("last_fault_addr", DATA_W'(want.fault_addr), DATA_W'(got.fault_addr));
            check_field("dev_address", DATA_W'(want.dev_addr), DATA_W'(got.dev_addr));
            check_field("dev_width", DATA_W'(want.dev_width), DATA_W'(got.dev_width));
            check_field("dev_value", want.dev_value, got.dev_value);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   gaps_on = 1'b1;
    int   stall_cycles = 0;
    bus_decode_checker sb;

    emb_in_if  in_bus ();
    emb_out_if out_bus ();
    emb_cfg_if cfg_bus ();

    emulated_memory_bus_decoder_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        out_bus.ready <= !gaps_on || ($urandom_range(0, 99) >= 29);
    end

    // sample the in and out channels, watch cfg, and guard against a hang
    always @(posedge i_clk) begin
        bus_access_t a;
        bus_result_t r;
        bit          moved;
        moved = 1'b0;
        if (i_rst_n === 1'b1) begin
            if (in_bus.valid && in_bus.ready) begin
                a.op    = t_op'(in_bus.operation);
                a.addr  = in_bus.bus_address;
                a.width = in_bus.width_bytes;
                a.value = in_bus.write_value;
                sb.note_access(a);
                moved = 1'b1;
            end
            if (out_bus.valid && out_bus.ready) begin
                r.read_data   = out_bus.read_data;
                r.status      = out_bus.status;
                r.fault_total = out_bus.fault_total;
                r.fault_addr  = out_bus.last_fault_addr;
                r.dev_addr    = out_bus.dev_address;
                r.dev_width   = out_bus.dev_width;
                r.dev_value   = out_bus.dev_value;
                sb.check_result(r);
                moved = 1'b1;
            end
            if (cfg_bus.valid && cfg_bus.ready) moved = 1'b1;
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_access(bus_access_t a);
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 99) < 29) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        // never read rom bytes that were not loaded; load the byte at the start address instead
        if (a.op == OP_READ && (a.width == 1 || a.width == 2 || a.width == 4)
                && a.addr < ROM_LIMIT && sb.rom_gap(a.addr, a.width)) begin
            a.op = OP_LOAD;
        end
        in_bus.operation   <= a.op;
        in_bus.bus_address <= a.addr;
        in_bus.width_bytes <= a.width;
        in_bus.write_value <= a.value;
        in_bus.valid       <= 1'b1;
        do @(posedge i_clk); while (!in_bus.ready);
    endtask

    task automatic access(t_op op, logic [ADDR_W-1:0] addr, logic [WIDTH_W-1:0] w,
                          logic [DATA_W-1:0] value);
        bus_access_t a;
        a.op    = op;
        a.addr  = addr;
        a.width = w;
        a.value = value;
        send_access(a);
    endtask

    task automatic wait_results_done();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROMLEN_W-1:0] data);
        @(negedge i_clk);
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        cfg_bus.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_bus.ready);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic configure(logic [ROMLEN_W-1:0] len, bit rd, bit wr);
        wait_results_done();
        write_reg(CFG_ROM_LENGTH, len);
        write_reg(CFG_DEV_READ, {22'd0, rd});
        write_reg(CFG_DEV_WRITE, {22'd0, wr});
    endtask

    function automatic logic [ADDR_W-1:0] rom_window_addr();
        int unsigned base;
        case ($urandom_range(0, 3))
            0: return ADDR_W'($urandom_range(0, 63));
            1: return 24'h3fffc0 + ADDR_W'($urandom_range(0, 63));
            2: begin
                base = (sb.rom_len > 8) ? sb.rom_len - 8 : 0;
                return ADDR_W'(base + $urandom_range(0, 15));
            end
            default: return ADDR_W'($urandom_range(0, 24'h3fffff));
        endcase
    endfunction

    function automatic bus_access_t random_access();
        bus_access_t a;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 40 || pick >= 95) a.op = OP_READ;
        else if (pick < 65) a.op = OP_WRITE;
        else if (pick < 92) a.op = OP_LOAD;
        else a.op = OP_BAD;
        if ($urandom_range(0, 99) < 94) begin
            case ($urandom_range(0, 2))
                0: a.width = 3'd1;
                1: a.width = 3'd2;
                default: a.width = 3'd4;
            endcase
        end else begin
            a.width = WIDTH_W'($urandom_range(0, 7));
        end
        a.value = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 4) a.addr = 24'hfffffc + ADDR_W'($urandom_range(0, 3));
        else if (pick < 25) a.addr = RAM_BASE | ADDR_W'($urandom_range(0, 65535));
        else if (pick < 65) a.addr = rom_window_addr();
        else if (pick < 70) a.addr = $urandom_range(0, 1) ? ROM_LIMIT : 24'hfeffff;
        else if (pick < 85) a.addr = ADDR_W'($urandom_range(24'h400000, 24'hfeffff));
        else a.addr = ADDR_W'($urandom);
        if (a.op == OP_LOAD && $urandom_range(0, 3) != 0) a.addr = rom_window_addr();
        return a;
    endfunction

    initial begin
        logic [ROMLEN_W-1:0] len_list [6];
        bit                  rd_list [6];
        bit                  wr_list [6];
        sb = new;
        len_list = '{23'd4194304, 23'd0, 23'd64, 23'd4194303, 23'd0, 23'd4194304};
        rd_list  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
        wr_list  = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
        len_list[4] = ROMLEN_W'($urandom_range(1, 4194304));
        rd_list[4]  = 1'($urandom_range(0, 1));
        wr_list[4]  = 1'($urandom_range(0, 1));

        i_rst_n             = 1'b0;
        in_bus.valid        = 1'b0;
        in_bus.operation    = OP_READ;
        in_bus.bus_address  = '0;
        in_bus.width_bytes  = '0;
        in_bus.write_value  = '0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = CFG_ROM_LENGTH;
        cfg_bus.data        = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        configure(23'd0, 1'b0, 1'b0);
        access(OP_READ,  24'h000000, 3'd1, 32'h0);
        access(OP_LOAD,  24'h000000, 3'd7, 32'h000000a5);
        access(OP_LOAD,  24'h000001, 3'd0, 32'hffffff5a);
        access(OP_LOAD,  24'h3fffff, 3'd1, 32'h0000003c);
        access(OP_LOAD,  24'h400000, 3'd1, 32'h0);
        access(OP_LOAD,  24'hffffff, 3'd4, 32'hffffffff);
        access(OP_WRITE, 24'hfffffe, 3'd4, 32'hdeadbeef);
        access(OP_READ,  24'hfffffe, 3'd4, 32'h0);
        access(OP_READ,  24'hff0000, 3'd2, 32'h0);
        access(OP_WRITE, 24'hff8000, 3'd1, 32'hffffffff);
        access(OP_READ,  24'hff7fff, 3'd4, 32'h0);
        access(OP_READ,  24'hff0000, 3'd0, 32'h0);
        access(OP_WRITE, 24'hff0000, 3'd3, 32'h12345678);
        access(OP_READ,  24'h000000, 3'd7, 32'h0);
        access(OP_BAD,   24'h123456, 3'd1, 32'h0);
        access(OP_WRITE, 24'h3fffff, 3'd4, 32'hffffffff);
        access(OP_READ,  24'h400000, 3'd4, 32'h0);
        access(OP_WRITE, 24'hfeffff, 3'd2, 32'h0000beef);
        configure(23'd4194304, 1'b1, 1'b1);
        access(OP_READ,  24'h000000, 3'd2, 32'h0);
        access(OP_READ,  24'h3fffff, 3'd1, 32'h0);
        access(OP_READ,  24'h3fffff, 3'd2, 32'h0);
        access(OP_READ,  24'h400000, 3'd4, 32'h0);
        access(OP_WRITE, 24'hfeffff, 3'd2, 32'hffffffff);
        access(OP_WRITE, 24'h800000, 3'd5, 32'h0);

        for (int phase = 0; phase < 6; phase++) begin
            configure(len_list[phase], rd_list[phase], wr_list[phase]);
            gaps_on = (phase != 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 0 && n == PHASE_ITEMS / 2) wait_results_done();
                send_access(random_access());
            end
        end
        gaps_on = 1'b1;

        wait_results_done();
        repeat (16) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/emb_pkg.sv
hw/rtl/emb_if.sv
hw/rtl/emb_ram.sv
hw/rtl/emb_decode.sv
hw/rtl/emulated_memory_bus_decoder_core.sv
test/tb_emulated_memory_bus_decoder_core.sv
